// ===== src/smr_pkg.sv =====
// package for the slice message reassembler: types, codes and default sizes
`default_nettype none
package smr_pkg;

   localparam int SLOT_COUNT_DEFAULT    = 5;
   localparam int MAX_ASSEMBLED_DEFAULT = 1024;

   localparam logic [7:0] MIN_LENGTH = 8'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic [9:0] read_offset;
   } req_type;

   typedef struct packed {
      logic [3:0] event_res;
      logic [7:0] msg_type;
      logic [5:0] msg_id;
      logic [1:0] version;
      logic [9:0] msg_length;
      logic [7:0] read_data;
      logic       read_beyond;
   } rsp_type;

   localparam logic [3:0] EV_PENDING   = 4'd0;
   localparam logic [3:0] EV_SINGLE    = 4'd1;
   localparam logic [3:0] EV_MULTI     = 4'd2;
   localparam logic [3:0] EV_OPENED    = 4'd3;
   localparam logic [3:0] EV_APPENDED  = 4'd4;
   localparam logic [3:0] EV_NO_MATCH  = 4'd5;
   localparam logic [3:0] EV_DROP      = 4'd6;
   localparam logic [3:0] EV_NO_SLOT   = 4'd7;
   localparam logic [3:0] EV_MALFORMED = 4'd8;
   localparam logic [3:0] EV_READ      = 4'd9;

   localparam logic [1:0] CODE_SINGLE = 2'd0;
   localparam logic [1:0] CODE_OPEN   = 2'd1;
   localparam logic [1:0] CODE_APPEND = 2'd2;
   localparam logic [1:0] CODE_LAST   = 2'd3;

   typedef enum logic [1:0] {
      CLS_NONE   = 2'd0,
      CLS_OPEN   = 2'd1,
      CLS_APPEND = 2'd2,
      CLS_LAST   = 2'd3
   } cls_type;

   typedef enum logic [1:0] {
      SUB_SINGLE  = 2'd0,
      SUB_NOMATCH = 2'd1,
      SUB_DROP    = 2'd2,
      SUB_NOSLOT  = 2'd3
   } sub_type;

   typedef struct packed {
      logic take_byte;
      logic take_read;
      logic read_finish;
      logic copy_step;
      logic copy_finish;
   } cmd_type;

   typedef struct packed {
      logic rsp_full;
      logic last_finish;
      logic copy_idle;
   } status_type;

endpackage
`default_nettype wire

// ===== src/smr_ram.sv =====
// generic single write port ram with one registered read port
`default_nettype none
module smr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/smr_ctrl.sv =====
// controller state machine: request acceptance, read wait and copy sweep
`default_nettype none
module smr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_command,
   output logic                     req_stall,
   input  wire logic                rsp_stall,
   input  wire smr_pkg::status_type status,
   output smr_pkg::cmd_type         cmd
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_COPY = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      req_stall = !((state_ff == ST_IDLE) && (!status.rsp_full || !rsp_stall));
      accept    = req_valid && !req_stall;
      cmd             = '0;
      cmd.take_byte   = accept && !req_command;
      cmd.take_read   = accept && req_command;
      state_in        = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take_read) begin
               state_in = ST_READ;
            end else if (cmd.take_byte && status.last_finish) begin
               state_in = ST_COPY;
            end
         end
         ST_READ: begin
            cmd.read_finish = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_idle) begin
               cmd.copy_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE))
      else $error("read wait lasted more than one cycle");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take_byte && status.last_finish) |=> (state_ff == ST_COPY))
      else $error("final slice did not start a copy");
endmodule
`default_nettype wire

// ===== src/smr_datapath.sv =====
// datapath: header capture, slot table, slot and delivery buffers, result register
`default_nettype none
module smr_datapath #(
   parameter int SLOT_COUNT    = smr_pkg::SLOT_COUNT_DEFAULT,
   parameter int MAX_ASSEMBLED = smr_pkg::MAX_ASSEMBLED_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire smr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smr_pkg::rsp_type      rsp_data,
   input  wire smr_pkg::cmd_type cmd,
   output smr_pkg::status_type   status
);
   localparam int FILL_W = $clog2(MAX_ASSEMBLED);
   localparam int SI_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SA_W   = $clog2(SLOT_COUNT * MAX_ASSEMBLED);
   localparam int CMP_W  = (FILL_W > 10) ? FILL_W : 10;

   // slot table
   logic              busy_ff     [SLOT_COUNT];
   logic [7:0]        stype_ff    [SLOT_COUNT];
   logic [5:0]        sid_ff      [SLOT_COUNT];
   logic [1:0]        sver_ff     [SLOT_COUNT];
   logic [5:0]        snext_ff    [SLOT_COUNT];
   logic [FILL_W-1:0] sfill_ff    [SLOT_COUNT];

   // delivered message
   logic [FILL_W-1:0] dlen_ff;
   logic [7:0]        dtype_ff;
   logic [1:0]        dver_ff;

   // header and slice position
   logic [7:0]        pos_ff;
   logic [7:0]        len_ff;
   logic [7:0]        b1_ff;
   logic [7:0]        type_ff;
   logic [7:0]        b3_ff;
   smr_pkg::cls_type  acls_ff;
   smr_pkg::sub_type  asub_ff;
   logic [SI_W-1:0]   aslot_ff;

   // copy and read bookkeeping
   logic [SI_W-1:0]   cslot_ff;
   logic [FILL_W-1:0] clen_ff;
   logic [FILL_W-1:0] crd_ff;
   logic [FILL_W-1:0] cwr_ff;
   logic              cpend_ff;
   logic              beyond_ff;

   logic              rsp_valid_ff;
   smr_pkg::rsp_type  rsp_data_ff;

   // combinational decode
   logic [5:0]        hid;
   logic [1:0]        hver;
   logic [7:0]        hb3;
   logic [7:0]        n;
   logic [1:0]        code;
   logic              free_found, match_found;
   logic [SI_W-1:0]   free_idx, match_idx;
   smr_pkg::cls_type  dec_cls, eff_cls;
   smr_pkg::sub_type  dec_sub, eff_sub;
   logic [SI_W-1:0]   dec_slot, eff_slot;
   logic [FILL_W:0]   sum;
   logic [FILL_W-1:0] fill_new;
   logic              at_decide, fin;
   logic              off_in_range;
   logic [SA_W-1:0]   eff_base, copy_base;

   logic              s_wr_en;
   logic [SA_W-1:0]   s_wr_addr, s_rd_addr;
   logic [7:0]        s_rd_data;
   logic              d_wr_en;
   logic [FILL_W-1:0] d_wr_addr, d_rd_addr;
   logic [7:0]        d_wr_data, d_rd_data;

   always_comb begin
      hb3       = (pos_ff == 8'd3) ? req_data.data_byte : b3_ff;
      hid       = hb3[7:2];
      hver      = hb3[1:0];
      code      = b1_ff[7:6];
      n         = len_ff - smr_pkg::MIN_LENGTH;
      at_decide = (pos_ff == 8'd3);
      fin       = (pos_ff >= 8'd3) && (pos_ff >= len_ff);

      free_found  = 1'b0;
      free_idx    = '0;
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SI_W'(i);
         end
         if (busy_ff[i] && (sid_ff[i] == hid) && (stype_ff[i] == type_ff)) begin
            match_found = 1'b1;
            match_idx   = SI_W'(i);
         end
      end

      sum      = (FILL_W + 1)'(sfill_ff[match_idx]) + (FILL_W + 1)'(n);
      dec_cls  = smr_pkg::CLS_NONE;
      dec_sub  = smr_pkg::SUB_SINGLE;
      dec_slot = '0;
      if (code == smr_pkg::CODE_SINGLE) begin
         dec_sub = smr_pkg::SUB_SINGLE;
      end else if (code == smr_pkg::CODE_OPEN) begin
         if (free_found) begin
            dec_cls  = smr_pkg::CLS_OPEN;
            dec_slot = free_idx;
         end else begin
            dec_sub = smr_pkg::SUB_NOSLOT;
         end
      end else if (!match_found) begin
         dec_sub = smr_pkg::SUB_NOMATCH;
      end else if ((sum < (FILL_W + 1)'(MAX_ASSEMBLED)) &&
                   (snext_ff[match_idx] == b1_ff[5:0])) begin
         dec_cls  = (code == smr_pkg::CODE_LAST) ? smr_pkg::CLS_LAST : smr_pkg::CLS_APPEND;
         dec_slot = match_idx;
      end else begin
         dec_sub  = smr_pkg::SUB_DROP;
         dec_slot = match_idx;
      end

      eff_cls  = at_decide ? dec_cls : acls_ff;
      eff_sub  = at_decide ? dec_sub : asub_ff;
      eff_slot = at_decide ? dec_slot : aslot_ff;
      fill_new = FILL_W'(sfill_ff[eff_slot] + FILL_W'(n));
      eff_base = SA_W'(eff_slot) * SA_W'(MAX_ASSEMBLED);
      copy_base = SA_W'(cslot_ff) * SA_W'(MAX_ASSEMBLED);

      off_in_range = CMP_W'(req_data.read_offset) < CMP_W'(dlen_ff);

      status.rsp_full    = rsp_valid_ff;
      status.last_finish = !req_data.command && (pos_ff != 8'd0) && fin &&
                           (eff_cls == smr_pkg::CLS_LAST);
      status.copy_idle   = (crd_ff == clen_ff) && !cpend_ff;

      // data bytes go straight to their target buffer
      s_wr_en   = cmd.take_byte && (pos_ff >= 8'd4) && (eff_cls != smr_pkg::CLS_NONE);
      s_wr_addr = eff_base + SA_W'(sfill_ff[eff_slot]) + SA_W'(pos_ff - 8'd4);
      s_rd_addr = copy_base + SA_W'(crd_ff);

      if (cpend_ff) begin
         d_wr_en   = 1'b1;
         d_wr_addr = cwr_ff;
         d_wr_data = s_rd_data;
      end else begin
         d_wr_en   = cmd.take_byte && (pos_ff >= 8'd4) && (eff_cls == smr_pkg::CLS_NONE) &&
                     (eff_sub == smr_pkg::SUB_SINGLE);
         d_wr_addr = FILL_W'(pos_ff - 8'd4);
         d_wr_data = req_data.data_byte;
      end
      d_rd_addr = FILL_W'(CMP_W'(req_data.read_offset));
   end

   smr_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT * MAX_ASSEMBLED)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (req_data.data_byte),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   smr_ram #(.WIDTH(8), .DEPTH(MAX_ASSEMBLED)) u_delivery_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         unique case (pos_ff)
            8'd0:    len_ff  <= req_data.data_byte;
            8'd1:    b1_ff   <= req_data.data_byte;
            8'd2:    type_ff <= req_data.data_byte;
            8'd3:    b3_ff   <= req_data.data_byte;
            default: ;
         endcase
      end
      if (cmd.take_read) begin
         beyond_ff <= !off_in_range;
      end
      if (cmd.take_byte && status.last_finish) begin
         cslot_ff <= eff_slot;
         clen_ff  <= fill_new;
      end
      if (cmd.copy_step && (crd_ff != clen_ff)) begin
         cwr_ff <= crd_ff;
      end

      if (cmd.take_byte) begin
         rsp_data_ff <= '0;
         if ((pos_ff == 8'd0) && (req_data.data_byte < smr_pkg::MIN_LENGTH)) begin
            rsp_data_ff.event_res <= smr_pkg::EV_MALFORMED;
         end else if ((pos_ff != 8'd0) && fin) begin
            rsp_data_ff.msg_type <= type_ff;
            rsp_data_ff.msg_id   <= hid;
            // an appended slice reports the version its slot was opened with
            rsp_data_ff.version  <= (eff_cls == smr_pkg::CLS_APPEND) ? sver_ff[eff_slot]
                                                                      : hver;
            unique case (eff_cls)
               smr_pkg::CLS_OPEN: begin
                  rsp_data_ff.event_res  <= smr_pkg::EV_OPENED;
                  rsp_data_ff.msg_length <= 10'(fill_new);
               end
               smr_pkg::CLS_APPEND: begin
                  rsp_data_ff.event_res  <= smr_pkg::EV_APPENDED;
                  rsp_data_ff.msg_length <= 10'(fill_new);
               end
               smr_pkg::CLS_LAST: ;
               smr_pkg::CLS_NONE: begin
                  unique case (eff_sub)
                     smr_pkg::SUB_SINGLE: begin
                        rsp_data_ff.event_res  <= smr_pkg::EV_SINGLE;
                        rsp_data_ff.msg_id     <= '0;
                        rsp_data_ff.msg_length <= 10'(n);
                     end
                     smr_pkg::SUB_NOMATCH: rsp_data_ff.event_res <= smr_pkg::EV_NO_MATCH;
                     smr_pkg::SUB_NOSLOT:  rsp_data_ff.event_res <= smr_pkg::EV_NO_SLOT;
                     smr_pkg::SUB_DROP:    rsp_data_ff.event_res <= smr_pkg::EV_DROP;
                     default:              rsp_data_ff.event_res <= smr_pkg::EV_DROP;
                  endcase
               end
               default: ;
            endcase
         end
      end else if (cmd.read_finish) begin
         rsp_data_ff.event_res   <= smr_pkg::EV_READ;
         rsp_data_ff.msg_type    <= dtype_ff;
         rsp_data_ff.msg_id      <= '0;
         rsp_data_ff.version     <= dver_ff;
         rsp_data_ff.msg_length  <= 10'(dlen_ff);
         rsp_data_ff.read_data   <= beyond_ff ? 8'd0 : d_rd_data;
         rsp_data_ff.read_beyond <= beyond_ff;
      end else if (cmd.copy_finish) begin
         rsp_data_ff.event_res   <= smr_pkg::EV_MULTI;
         rsp_data_ff.msg_type    <= stype_ff[cslot_ff];
         rsp_data_ff.msg_id      <= '0;
         rsp_data_ff.version     <= sver_ff[cslot_ff];
         rsp_data_ff.msg_length  <= 10'(clen_ff);
         rsp_data_ff.read_data   <= '0;
         rsp_data_ff.read_beyond <= 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_ff[i]  <= 1'b0;
            stype_ff[i] <= '0;
            sid_ff[i]   <= '0;
            sver_ff[i]  <= '0;
            snext_ff[i] <= '0;
            sfill_ff[i] <= '0;
         end
         dlen_ff      <= '0;
         dtype_ff     <= '0;
         dver_ff      <= '0;
         pos_ff       <= '0;
         acls_ff      <= smr_pkg::CLS_NONE;
         asub_ff      <= smr_pkg::SUB_SINGLE;
         aslot_ff     <= '0;
         crd_ff       <= '0;
         cpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((cmd.take_byte && !status.last_finish) || cmd.read_finish || cmd.copy_finish) begin
            rsp_valid_ff <= 1'b1;
         end

         if (cmd.take_byte) begin
            if ((pos_ff == 8'd0) && (req_data.data_byte < smr_pkg::MIN_LENGTH)) begin
               pos_ff <= '0;
            end else if ((pos_ff != 8'd0) && fin) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 8'd1;
            end

            if (at_decide) begin
               acls_ff  <= dec_cls;
               asub_ff  <= dec_sub;
               aslot_ff <= dec_slot;
               if (code == smr_pkg::CODE_SINGLE) begin
                  dlen_ff  <= '0;
                  dtype_ff <= type_ff;
                  dver_ff  <= hver;
               end else if (dec_cls == smr_pkg::CLS_OPEN) begin
                  busy_ff[dec_slot]  <= 1'b1;
                  stype_ff[dec_slot] <= type_ff;
                  sid_ff[dec_slot]   <= hid;
                  sver_ff[dec_slot]  <= hver;
                  snext_ff[dec_slot] <= b1_ff[5:0] + 6'd1;
                  sfill_ff[dec_slot] <= '0;
               end else if (dec_sub == smr_pkg::SUB_DROP) begin
                  busy_ff[dec_slot]  <= 1'b0;
                  snext_ff[dec_slot] <= '0;
                  sfill_ff[dec_slot] <= '0;
               end
            end

            if ((pos_ff != 8'd0) && fin) begin
               if (eff_cls != smr_pkg::CLS_NONE) begin
                  sfill_ff[eff_slot] <= fill_new;
               end
               if (eff_cls == smr_pkg::CLS_APPEND) begin
                  snext_ff[eff_slot] <= snext_ff[eff_slot] + 6'd1;
               end
               if ((eff_cls == smr_pkg::CLS_NONE) && (eff_sub == smr_pkg::SUB_SINGLE)) begin
                  dlen_ff <= FILL_W'(n);
               end
               if (eff_cls == smr_pkg::CLS_LAST) begin
                  crd_ff   <= '0;
                  cpend_ff <= 1'b0;
               end
            end
         end

         if (cmd.copy_step) begin
            if (crd_ff != clen_ff) begin
               crd_ff   <= crd_ff + FILL_W'(1);
               cpend_ff <= 1'b1;
            end else begin
               cpend_ff <= 1'b0;
            end
         end

         if (cmd.copy_finish) begin
            dlen_ff            <= clen_ff;
            dtype_ff           <= stype_ff[cslot_ff];
            dver_ff            <= sver_ff[cslot_ff];
            busy_ff[cslot_ff]  <= 1'b0;
            snext_ff[cslot_ff] <= '0;
            sfill_ff[cslot_ff] <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      (cmd.read_finish || cmd.copy_finish) |-> !rsp_valid_ff)
      else $error("result register still full when a late result lands");
   assert property (@(posedge clock) disable iff (reset)
      cmd.take_byte |-> !cpend_ff)
      else $error("slice byte taken while the copy still writes");
   assert property (@(posedge clock) disable iff (reset)
      cmd.copy_finish |-> busy_ff[cslot_ff])
      else $error("copy finished on a slot that is not busy");
endmodule
`default_nettype wire

// ===== src/slice_message_reassembler.sv =====
// slice message reassembler: joins the controller and the datapath
// slice bytes: result registered in the result register as each byte is taken
// reads: registered delivery buffer read during the read wait state, then the result register
// final slice of a message: a copy sweep moves the fill out of the slot buffer first
// sustained: one slice byte per cycle while req_stall is low; a read holds off requests
// synchronous reset frees every slot and clears delivered length; buffers need no clearing
`default_nettype none
module slice_message_reassembler #(
   parameter int SLOT_COUNT    = smr_pkg::SLOT_COUNT_DEFAULT,
   parameter int MAX_ASSEMBLED = smr_pkg::MAX_ASSEMBLED_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire smr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smr_pkg::rsp_type      rsp_data
);
   smr_pkg::cmd_type    cmd;
   smr_pkg::status_type status;

   smr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   smr_datapath #(
      .SLOT_COUNT    (SLOT_COUNT),
      .MAX_ASSEMBLED (MAX_ASSEMBLED)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
`default_nettype wire

// ===== test/slice_message_reassembler_checker.sv =====
// checker for the slice message reassembler: predicts every result and compares it
module slice_message_reassembler_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  smr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  smr_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               request_count,
   output int               multi_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = smr_pkg::SLOT_COUNT_DEFAULT;
   localparam int CAP   = smr_pkg::MAX_ASSEMBLED_DEFAULT;

   logic [7:0]  slot_data [SLOTS][CAP];
   logic        busy [SLOTS];
   logic [7:0]  s_type [SLOTS];
   logic [5:0]  s_id [SLOTS];
   logic [1:0]  s_ver [SLOTS];
   logic [5:0]  s_seq [SLOTS];
   int          s_fill [SLOTS];
   logic [7:0]  msg_data [CAP];
   int          msg_len;
   logic [7:0]  msg_ty;
   logic [1:0]  msg_ver;
   int          position;
   logic [31:0] header;
   smr_pkg::cls_type route_cls;
   smr_pkg::sub_type route_sub;
   int          route_slot;

   smr_pkg::rsp_type expected_rsps [$];

   function automatic void release_slot(int s);
      busy[s] = 1'b0;
      s_fill[s] = 0;
      s_seq[s] = '0;
   endfunction

   function automatic void route_slice();
      logic [1:0] code;
      logic [5:0] seq;
      logic [7:0] ty;
      logic [5:0] id;
      logic [1:0] ver;
      int n;
      int s;
      code = header[15:14];
      seq = header[13:8];
      ty = header[23:16];
      id = header[31:26];
      ver = header[25:24];
      n = int'(header[7:0]) - 3;
      route_cls = smr_pkg::CLS_NONE;
      if (code == smr_pkg::CODE_SINGLE) begin
         msg_len = 0;
         msg_ty = ty;
         msg_ver = ver;
         route_sub = smr_pkg::SUB_SINGLE;
         return;
      end
      if (code == smr_pkg::CODE_OPEN) begin
         for (s = 0; s < SLOTS; s++)
            if (!busy[s]) break;
         if (s >= SLOTS) begin
            route_sub = smr_pkg::SUB_NOSLOT;
         end else if (n >= CAP) begin
            route_sub = smr_pkg::SUB_DROP;
         end else begin
            busy[s] = 1'b1;
            s_type[s] = ty;
            s_id[s] = id;
            s_ver[s] = ver;
            s_seq[s] = seq + 6'd1;
            s_fill[s] = 0;
            route_cls = smr_pkg::CLS_OPEN;
            route_slot = s;
         end
         return;
      end
      for (s = 0; s < SLOTS; s++)
         if (busy[s] && s_id[s] == id && s_type[s] == ty) break;
      if (s >= SLOTS) begin
         route_sub = smr_pkg::SUB_NOMATCH;
      end else if (s_fill[s] + n < CAP && s_seq[s] == seq) begin
         route_cls = (code == smr_pkg::CODE_LAST) ? smr_pkg::CLS_LAST : smr_pkg::CLS_APPEND;
         route_slot = s;
      end else begin
         release_slot(s);
         route_sub = smr_pkg::SUB_DROP;
      end
   endfunction

   function automatic smr_pkg::rsp_type close_slice();
      smr_pkg::rsp_type o;
      int n;
      int s;
      o = '0;
      n = int'(header[7:0]) - 3;
      s = route_slot;
      if (route_cls == smr_pkg::CLS_NONE) begin
         o.msg_type = header[23:16];
         o.msg_id = header[31:26];
         o.version = header[25:24];
         case (route_sub)
            smr_pkg::SUB_SINGLE: begin
               msg_len = n;
               o.event_res = smr_pkg::EV_SINGLE;
               o.msg_type = msg_ty;
               o.msg_id = '0;
               o.version = msg_ver;
               o.msg_length = 10'(n);
            end
            smr_pkg::SUB_NOMATCH: o.event_res = smr_pkg::EV_NO_MATCH;
            smr_pkg::SUB_NOSLOT: o.event_res = smr_pkg::EV_NO_SLOT;
            default: o.event_res = smr_pkg::EV_DROP;
         endcase
         return o;
      end
      s_fill[s] += n;
      o.msg_type = s_type[s];
      o.msg_id = s_id[s];
      o.version = s_ver[s];
      o.msg_length = 10'(s_fill[s]);
      if (route_cls == smr_pkg::CLS_OPEN) begin
         o.event_res = smr_pkg::EV_OPENED;
      end else if (route_cls == smr_pkg::CLS_APPEND) begin
         s_seq[s] = s_seq[s] + 6'd1;
         o.event_res = smr_pkg::EV_APPENDED;
      end else begin
         for (int k = 0; k < s_fill[s]; k++) msg_data[k] = slot_data[s][k];
         msg_len = s_fill[s];
         msg_ty = s_type[s];
         msg_ver = s_ver[s];
         release_slot(s);
         o.event_res = smr_pkg::EV_MULTI;
         o.msg_id = '0;
      end
      return o;
   endfunction

   function automatic smr_pkg::rsp_type reassemble(smr_pkg::req_type r);
      smr_pkg::rsp_type o;
      int cur;
      o = '0;
      if (r.command) begin
         o.event_res = smr_pkg::EV_READ;
         o.msg_type = msg_ty;
         o.version = msg_ver;
         o.msg_length = 10'(msg_len);
         if (int'(r.read_offset) < msg_len) o.read_data = msg_data[r.read_offset];
         else o.read_beyond = 1'b1;
         return o;
      end
      cur = position;
      if (cur == 0) begin
         if (r.data_byte < smr_pkg::MIN_LENGTH) begin
            o.event_res = smr_pkg::EV_MALFORMED;
            return o;
         end
         header = {24'd0, r.data_byte};
      end else if (cur <= 3) begin
         header[8*cur +: 8] = r.data_byte;
         if (cur == 3) route_slice();
      end else if (route_cls == smr_pkg::CLS_NONE) begin
         if (route_sub == smr_pkg::SUB_SINGLE && cur - 4 < CAP) msg_data[cur-4] = r.data_byte;
      end else if (s_fill[route_slot] + cur - 4 < CAP) begin
         slot_data[route_slot][s_fill[route_slot] + cur - 4] = r.data_byte;
      end
      if (cur >= 3 && cur >= int'(header[7:0])) begin
         o = close_slice();
         position = 0;
      end else begin
         position = (cur + 1) & 255;
      end
      return o;
   endfunction

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         release_slot(s);
         s_type[s] = '0;
         s_id[s] = '0;
         s_ver[s] = '0;
      end
      msg_len = 0;
      msg_ty = '0;
      msg_ver = '0;
      position = 0;
      header = '0;
      route_cls = smr_pkg::CLS_NONE;
      route_sub = smr_pkg::SUB_SINGLE;
      route_slot = 0;
      fail_count = 0;
      request_count = 0;
      multi_count = 0;
   end

   assign pending = expected_rsps.size();

   always @(posedge clock) begin
      smr_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(reassemble(req_data));
            request_count <= request_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want.event_res == smr_pkg::EV_MULTI) multi_count <= multi_count + 1;
               if (want != rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (want.event_res != rsp_data.event_res)
                     $error("event_res: expected %0d, got %0d", want.event_res,
                            rsp_data.event_res);
                  if (want.msg_type != rsp_data.msg_type)
                     $error("msg_type: expected %0h, got %0h", want.msg_type,
                            rsp_data.msg_type);
                  if (want.msg_id != rsp_data.msg_id)
                     $error("msg_id: expected %0h, got %0h", want.msg_id, rsp_data.msg_id);
                  if (want.version != rsp_data.version)
                     $error("version: expected %0d, got %0d", want.version,
                            rsp_data.version);
                  if (want.msg_length != rsp_data.msg_length)
                     $error("msg_length: expected %0d, got %0d", want.msg_length,
                            rsp_data.msg_length);
                  if (want.read_data != rsp_data.read_data)
                     $error("read_data: expected %0h, got %0h", want.read_data,
                            rsp_data.read_data);
                  if (want.read_beyond != rsp_data.read_beyond)
                     $error("read_beyond: expected %0d, got %0d", want.read_beyond,
                            rsp_data.read_beyond);
               end
            end
         end
      end
   end

endmodule

// ===== test/slice_message_reassembler_test.sv =====
// top of the slice message reassembler testbench: clock, reset, stimulus and verdict
module slice_message_reassembler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEM_TARGET = 1850;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   smr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   smr_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int request_count;
   int multi_count;
   int sent = 0;
   int cycles = 0;
   bit no_gaps = 1'b0;
   int hold_off = 0;

   typedef struct {
      logic [7:0] ty;
      logic [5:0] id;
      logic [5:0] seq;
   } open_msg_type;
   open_msg_type open_msgs [$];

   slice_message_reassembler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   slice_message_reassembler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .request_count (request_count),
      .multi_count   (multi_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("slice_message_reassembler: mismatch");
         $finish;
      end
   end

   task automatic send(input smr_pkg::req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      smr_pkg::req_type r;
      r.command = 1'b0;
      r.data_byte = b;
      r.read_offset = 10'($urandom);
      send(r);
   endtask

   task automatic send_read(input logic [9:0] offset);
      smr_pkg::req_type r;
      r.command = 1'b1;
      r.data_byte = 8'($urandom);
      r.read_offset = offset;
      send(r);
   endtask

   task automatic send_slice(input logic [7:0] len, input logic [1:0] code,
                             input logic [5:0] seq, input logic [7:0] ty,
                             input logic [5:0] id, input logic [1:0] ver);
      send_byte(len);
      send_byte({code, seq});
      send_byte(ty);
      send_byte({id, ver});
      for (int k = 3; k < len; k++) begin
         if ($urandom_range(0, 19) == 0) send_read(10'($urandom_range(0, 31)));
         send_byte(8'($urandom));
      end
   endtask

   function automatic logic [7:0] pick_length();
      return ($urandom_range(0, 29) == 0) ? 8'($urandom_range(200, 255))
                                          : 8'($urandom_range(3, 12));
   endfunction

   task automatic whole_message();
      logic [7:0] ty;
      logic [5:0] id;
      logic [5:0] seq;
      logic [1:0] ver;
      int parts;
      ty = 8'($urandom);
      id = 6'($urandom);
      seq = 6'($urandom);
      ver = 2'($urandom);
      parts = $urandom_range(0, 3);
      send_slice(pick_length(), smr_pkg::CODE_OPEN, seq, ty, id, ver);
      for (int p = 0; p < parts; p++) begin
         seq++;
         send_slice(pick_length(), smr_pkg::CODE_APPEND, seq, ty, id, 2'($urandom));
      end
      seq++;
      send_slice(pick_length(), smr_pkg::CODE_LAST, seq, ty, id, 2'($urandom));
      repeat ($urandom_range(1, 3)) send_read(10'($urandom_range(0, 15)));
   endtask

   initial begin
      forever begin
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end else begin
            int wait_cycles;
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 13);
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end
      end
   end

   initial begin
      open_msg_type m;
      int pick;
      bit pressed;
      pressed = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening
      send_byte(8'd0);
      send_byte(8'd2);
      send_slice(8'd3, smr_pkg::CODE_SINGLE, 6'd63, 8'hFF, 6'd63, 2'd3);
      send_read(10'd0);
      send_slice(8'd5, smr_pkg::CODE_OPEN, 6'd63, 8'h00, 6'd0, 2'd0);
      send_slice(8'd3, smr_pkg::CODE_APPEND, 6'd0, 8'h00, 6'd0, 2'd1);
      send_slice(8'd4, smr_pkg::CODE_LAST, 6'd1, 8'h00, 6'd0, 2'd2);
      send_read(10'd0);
      send_read(10'd1023);

      // one message grown until it overflows its slot, then a large one delivered
      send_slice(8'd255, smr_pkg::CODE_OPEN, 6'd10, 8'h5A, 6'd42, 2'd1);
      for (int p = 1; p <= 4; p++)
         send_slice(8'd255, smr_pkg::CODE_APPEND, 6'(10 + p), 8'h5A, 6'd42, 2'd1);
      send_slice(8'd255, smr_pkg::CODE_OPEN, 6'd20, 8'hA5, 6'd21, 2'd2);
      send_slice(8'd3, smr_pkg::CODE_LAST, 6'd21, 8'hA5, 6'd21, 2'd2);
      send_read(10'd251);
      send_read(10'd252);
      send_read(10'd128);

      while (sent < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) no_gaps = ~no_gaps;
         if (!pressed && sent > ITEM_TARGET / 2) begin
            pressed = 1'b1;
            hold_off = 400;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            whole_message();
         end else if (pick < 55) begin
            send_slice(pick_length(), smr_pkg::CODE_SINGLE, 6'($urandom), 8'($urandom),
                       6'($urandom), 2'($urandom));
         end else if (pick < 65) begin
            m.ty = 8'($urandom_range(0, 3));
            m.id = 6'($urandom_range(0, 3));
            m.seq = 6'($urandom);
            send_slice(pick_length(), smr_pkg::CODE_OPEN, m.seq, m.ty, m.id, 2'($urandom));
            m.seq++;
            if (open_msgs.size() < 7) open_msgs.push_back(m);
         end else if (pick < 75 && open_msgs.size() > 0) begin
            m = open_msgs.pop_front();
            if ($urandom_range(0, 1)) begin
               send_slice(pick_length(), smr_pkg::CODE_APPEND, m.seq, m.ty, m.id,
                          2'($urandom));
               m.seq++;
               open_msgs.push_back(m);
            end else begin
               send_slice(pick_length(), smr_pkg::CODE_LAST, m.seq, m.ty, m.id,
                          2'($urandom));
            end
         end else if (pick < 80) begin
            if (open_msgs.size() > 0 && $urandom_range(0, 1)) begin
               m = open_msgs.pop_front();
               send_slice(pick_length(), 2'($urandom_range(2, 3)), m.seq + 6'd1, m.ty,
                          m.id, 2'($urandom));
            end else begin
               send_slice(pick_length(), 2'($urandom_range(2, 3)), 6'($urandom),
                          8'($urandom), 6'($urandom), 2'($urandom));
            end
         end else if (pick < 85) begin
            send_byte(8'($urandom_range(0, 2)));
         end else begin
            repeat ($urandom_range(1, 3))
               send_read($urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 15)));
         end
      end

      req_valid <= 1'b0;
      while (pending > 0) @(posedge clock);
      repeat (1100) @(posedge clock);

      $display("%0d requests went in; %0d messages were rebuilt from several slices",
               request_count, multi_count);
      if (fail_count == 0) begin
         $display("slice_message_reassembler: match");
      end else begin
         $display("slice_message_reassembler: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/smr_pkg.sv
src/smr_ram.sv
src/smr_ctrl.sv
src/smr_datapath.sv
src/slice_message_reassembler.sv
test/slice_message_reassembler_checker.sv
test/slice_message_reassembler_test.sv
